// ===== sv/cfa_pkg.sv =====
// Shared types, constants and tables for the complementary filter attitude unit.
package cfa_pkg;

  localparam int CordicSteps = 16;
  localparam int SampleBits  = 16;
  localparam int CordW       = SampleBits + 20;
  localparam int ZW          = 26;
  localparam int CntW        = 5;
  localparam int AngW        = 18;
  localparam int CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] CfgBlend = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDecl  = 2'd1;

  localparam logic [15:0] BlendReset = 16'd63570;
  localparam logic [16:0] DeclReset  = 17'd1777;

  localparam logic signed [ZW-1:0] HalfTurn = 26'sd11796480;
  localparam logic signed [29:0]   AngLimit = 30'sd92160;
  localparam logic [25:0]          Recip125 = 26'd34359738;

  localparam logic [21:0] AtanFine [24] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic [15:0]        elapsed_ms;
  } cfa_item_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } cfa_qstat_t;

endpackage

// ===== sv/complementary_filter_attitude_unit.sv =====
// Top level of the complementary filter attitude unit: queue, sequencer, config registers.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   accel, gyro, mag axes, elapsed_ms
//  out      output     out_valid_o / out_stall_i pitch, roll, heading
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample set runs through the shared sequencer in turn: pitch and roll each take
// square root, CORDIC, prediction and blend; heading skips the square root.
// A zero vector skips its CORDIC iterations. A two-entry queue takes sets meanwhile.
// Reset clears the angles and loads the default weight and declination.
// A stalled result holds in the output register; the sequencer waits behind it.
module complementary_filter_attitude_unit import cfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     accel_x_i,
  input  logic signed [15:0]     accel_y_i,
  input  logic signed [15:0]     accel_z_i,
  input  logic signed [15:0]     gyro_x_i,
  input  logic signed [15:0]     gyro_y_i,
  input  logic signed [15:0]     gyro_z_i,
  input  logic signed [15:0]     mag_x_i,
  input  logic signed [15:0]     mag_y_i,
  input  logic signed [15:0]     mag_z_i,
  input  logic [15:0]            elapsed_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AngW-1:0] pitch_o,
  output logic signed [AngW-1:0] roll_o,
  output logic signed [AngW-1:0] heading_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [16:0]            cfg_data_i
);

  cfa_item_t          in_item, q_item;
  cfa_qstat_t         q_stat;
  logic               q_valid, q_pop;
  logic [15:0]        blend_q, blend_d;
  logic signed [16:0] decl_q, decl_d;

  assign cfg_ready_o = 1'b1;

  assign in_item.accel_x    = accel_x_i;
  assign in_item.accel_y    = accel_y_i;
  assign in_item.accel_z    = accel_z_i;
  assign in_item.gyro_x     = gyro_x_i;
  assign in_item.gyro_y     = gyro_y_i;
  assign in_item.gyro_z     = gyro_z_i;
  assign in_item.mag_x      = mag_x_i;
  assign in_item.mag_y      = mag_y_i;
  assign in_item.mag_z      = mag_z_i;
  assign in_item.elapsed_ms = elapsed_ms_i;

  always_comb begin
    blend_d = blend_q;
    decl_d  = decl_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBlend: blend_d = cfg_data_i[15:0];
        CfgDecl:  decl_d  = $signed(cfg_data_i);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= BlendReset;
      decl_q  <= $signed(DeclReset);
    end else begin
      blend_q <= blend_d;
      decl_q  <= decl_d;
    end
  end

  cfa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop),
    .q_stat_o   (q_stat)
  );

  cfa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .blend_weight_i (blend_q),
    .declination_i  (decl_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pitch_o        (pitch_o),
    .roll_o         (roll_o),
    .heading_o      (heading_o)
  );

`ifndef SYNTH
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_o <= 18'sd92160 && pitch_o >= -18'sd92160 &&
                     roll_o <= 18'sd92160 && roll_o >= -18'sd92160 &&
                     heading_o <= 18'sd92160 && heading_o >= -18'sd92160))
    else $error("result angle out of range");

  a_queue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count != 2'd3 && !(q_stat.full && q_stat.empty))
    else $error("queue count inconsistent");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/cfa_front.sv =====
// Input side: accepts sample sets and queues them for the compute sequencer.
module cfa_front import cfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cfa_item_t  in_item_i,
  output logic       q_valid_o,
  output cfa_item_t  q_item_o,
  input  logic       q_pop_i,
  output cfa_qstat_t q_stat_o
);

  cfa_item_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  assign q_stat_o.full  = (cnt_q == 2'd2);
  assign q_stat_o.empty = (cnt_q == 2'd0);
  assign q_stat_o.count = cnt_q;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

endmodule

// ===== sv/cfa_back.sv =====
// Compute sequencer: square root (pitch and roll), CORDIC atan2, gyro prediction and blend per angle.
module cfa_back import cfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  cfa_item_t              q_item_i,
  output logic                   q_pop_o,
  input  logic [15:0]            blend_weight_i,
  input  logic signed [16:0]     declination_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AngW-1:0] pitch_o,
  output logic signed [AngW-1:0] roll_o,
  output logic signed [AngW-1:0] heading_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSq0   = 4'd1;
  localparam logic [3:0] StSq1   = 4'd2;
  localparam logic [3:0] StSqrt  = 4'd3;
  localparam logic [3:0] StCinit = 4'd4;
  localparam logic [3:0] StCord  = 4'd5;
  localparam logic [3:0] StCdone = 4'd6;
  localparam logic [3:0] StRate  = 4'd7;
  localparam logic [3:0] StRecip = 4'd8;
  localparam logic [3:0] StCorr  = 4'd9;
  localparam logic [3:0] StBl0   = 4'd10;
  localparam logic [3:0] StBl1   = 4'd11;
  localparam logic [3:0] StBl2   = 4'd12;
  localparam logic [3:0] StOut   = 4'd13;

  logic [3:0]            st_q, st_d;
  logic [1:0]            k_q, k_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  cfa_item_t             item_q, item_d;
  logic [31:0]           sq_q, sq_d, root_q, root_d, bit_q, bit_d;
  logic signed [CordW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0]  cz_q, cz_d;
  logic signed [18:0]    meas_q, meas_d;
  logic                  neg_q, neg_d;
  logic [29:0]           nh_q, nh_d;
  logic [23:0]           q0_q, q0_d;
  logic signed [25:0]    pred_q, pred_d;
  logic signed [44:0]    acc_q, acc_d;
  logic signed [AngW-1:0] ang_q [3];
  logic signed [AngW-1:0] ang_d [3];
  logic                  ov_q, ov_d;
  logic signed [AngW-1:0] op_q, op_d, or_q, or_d, oh_q, oh_d;

  logic signed [15:0]    sq_a, rate;
  logic signed [31:0]    sq_p;
  logic [32:0]           rb_sum;
  logic signed [17:0]    cy0, cx0;
  logic signed [CordW-1:0] cxi, cyi, xs, ys;
  logic [ZW-1:0]         zmag, zsum;
  logic signed [18:0]    mbase, decl19;
  logic signed [32:0]    rprod, rmag;
  logic [30:0]           nsum;
  logic [55:0]           qprod;
  logic [30:0]           qmul;
  logic [30:0]           rem;
  logic [23:0]           qf;
  logic signed [25:0]    inc;
  logic signed [42:0]    m0;
  logic [16:0]           beta;
  logic signed [36:0]    m1;
  logic [44:0]           amag, asum;
  logic signed [29:0]    vr;

  assign out_valid_o = ov_q;
  assign pitch_o     = op_q;
  assign roll_o      = or_q;
  assign heading_o   = oh_q;

  always_comb begin
    st_d    = st_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    item_d  = item_q;
    sq_d    = sq_q;
    root_d  = root_q;
    bit_d   = bit_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    meas_d  = meas_q;
    neg_d   = neg_q;
    nh_d    = nh_q;
    q0_d    = q0_q;
    pred_d  = pred_q;
    acc_d   = acc_q;
    ang_d   = ang_q;
    ov_d    = ov_q && out_stall_i;
    op_d    = op_q;
    or_d    = or_q;
    oh_d    = oh_q;
    q_pop_o = 1'b0;

    sq_a   = (k_q == 2'd0) ? item_q.accel_x : item_q.accel_y;
    sq_p   = (st_q == StSq0) ? sq_a * sq_a : item_q.accel_z * item_q.accel_z;
    rb_sum = {1'b0, root_q} + {1'b0, bit_q};

    case (k_q)
      2'd0:    cy0 = {{2{item_q.accel_y[15]}}, item_q.accel_y};
      2'd1:    cy0 = -{{2{item_q.accel_x[15]}}, item_q.accel_x};
      default: cy0 = {{2{item_q.mag_y[15]}}, item_q.mag_y};
    endcase
    cx0 = (k_q == 2'd2) ? {{2{item_q.mag_x[15]}}, item_q.mag_x}
                        : $signed({2'b00, root_q[15:0]});
    cxi = $signed({{(CordW-18){cx0[17]}}, cx0}) <<< SampleBits;
    cyi = $signed({{(CordW-18){cy0[17]}}, cy0}) <<< SampleBits;
    xs  = cx_q >>> cnt_q;
    ys  = cy_q >>> cnt_q;

    zmag   = cz_q[ZW-1] ? ZW'(-cz_q) : ZW'(cz_q);
    zsum   = zmag + ZW'(128);
    mbase  = cz_q[ZW-1] ? -$signed({1'b0, zsum[ZW-1:8]}) : $signed({1'b0, zsum[ZW-1:8]});
    decl19 = {{2{declination_i[16]}}, declination_i};

    case (k_q)
      2'd0:    rate = item_q.gyro_x;
      2'd1:    rate = item_q.gyro_y;
      default: rate = item_q.gyro_z;
    endcase
    rprod = rate * $signed({1'b0, item_q.elapsed_ms});
    rmag  = rprod[32] ? -rprod : rprod;
    nsum  = rmag[30:0] + 31'd125;

    qprod = {26'd0, nh_q} * {30'd0, Recip125};
    qmul  = 31'({7'd0, q0_q} * 31'd125);
    rem   = {1'b0, nh_q} - qmul;
    qf    = q0_q + {23'd0, (rem >= 31'd125)};
    inc   = neg_q ? -$signed({2'b00, qf}) : $signed({2'b00, qf});

    m0   = $signed({1'b0, blend_weight_i}) * pred_q;
    beta = 17'h10000 - {1'b0, blend_weight_i};
    m1   = $signed({1'b0, beta}) * meas_q;
    amag = acc_q[44] ? 45'(-acc_q) : 45'(acc_q);
    asum = amag + 45'd32768;
    vr   = acc_q[44] ? -$signed({1'b0, asum[44:16]}) : $signed({1'b0, asum[44:16]});

    unique case (st_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          k_d     = 2'd0;
          st_d    = StSq0;
        end
      end
      StSq0: begin
        sq_d = 32'(sq_p);
        st_d = StSq1;
      end
      StSq1: begin
        sq_d   = sq_q + 32'(sq_p);
        root_d = 32'd0;
        bit_d  = 32'h4000_0000;
        cnt_d  = '0;
        st_d   = StSqrt;
      end
      StSqrt: begin
        if ({1'b0, sq_q} >= rb_sum) begin
          sq_d   = sq_q - rb_sum[31:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(15)) begin
          st_d = StCinit;
        end
      end
      StCinit: begin
        cnt_d = '0;
        if (cx0 == 18'sd0 && cy0 == 18'sd0) begin
          cz_d = '0;
          st_d = StCdone;
        end else begin
          st_d = StCord;
          if (cx0 < 0) begin
            cx_d = -cxi;
            cy_d = -cyi;
            cz_d = (cy0 >= 0) ? HalfTurn : -HalfTurn;
          end else begin
            cx_d = cxi;
            cy_d = cyi;
            cz_d = '0;
          end
        end
      end
      StCord: begin
        if (cy_q > 0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + $signed({4'b0, AtanFine[cnt_q]});
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - $signed({4'b0, AtanFine[cnt_q]});
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          st_d = StCdone;
        end
      end
      StCdone: begin
        meas_d = (k_q == 2'd2) ? mbase + decl19 : mbase;
        st_d   = StRate;
      end
      StRate: begin
        neg_d = rprod[32];
        nh_d  = nsum[30:1];
        st_d  = StRecip;
      end
      StRecip: begin
        q0_d = qprod[55:32];
        st_d = StCorr;
      end
      StCorr: begin
        pred_d = {{8{ang_q[k_q][AngW-1]}}, ang_q[k_q]} + inc;
        st_d   = StBl0;
      end
      StBl0: begin
        acc_d = {{2{m0[42]}}, m0};
        st_d  = StBl1;
      end
      StBl1: begin
        acc_d = acc_q + {{8{m1[36]}}, m1};
        st_d  = StBl2;
      end
      StBl2: begin
        if (vr > AngLimit) begin
          ang_d[k_q] = AngW'(AngLimit);
        end else if (vr < -AngLimit) begin
          ang_d[k_q] = AngW'(-AngLimit);
        end else begin
          ang_d[k_q] = AngW'(vr);
        end
        if (k_q == 2'd2) begin
          st_d = StOut;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = (k_q == 2'd1) ? StCinit : StSq0;
        end
      end
      StOut: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          op_d = ang_q[0];
          or_d = ang_q[1];
          oh_d = ang_q[2];
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      k_q   <= 2'd0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      ang_q <= '{default: '0};
    end else begin
      st_q  <= st_d;
      k_q   <= k_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      ang_q <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sq_q   <= sq_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    meas_q <= meas_d;
    neg_q  <= neg_d;
    nh_q   <= nh_d;
    q0_q   <= q0_d;
    pred_q <= pred_d;
    acc_q  <= acc_d;
    op_q   <= op_d;
    or_q   <= or_d;
    oh_q   <= oh_d;
  end

endmodule
